// File: rtl/core/prgq_pkg.sv
`timescale 1ns / 1ps

package prgq_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int QUO_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int CHANNELS   = 3;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = QUO_W / DIV_STAGES;
  localparam int SQRT_STAGES = 2;
  localparam int SQRT_STEPS = BYTE_W / SQRT_STAGES;
  localparam int ROOT_REM_W = BYTE_W + 2;

  localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

  // Partial remainder and a word that holds the dividend bits still to come
  // at the top and the quotient bits already found at the bottom.
  typedef struct packed {
    logic [QUO_W-1:0] rem;
    logic [QUO_W-1:0] word;
  } div_chan_t;

  typedef struct packed {
    div_chan_t [CHANNELS-1:0] ch;
    logic [CHANNELS-1:0]      sat;
    logic                     frame_end;
  } div_pipe_t;

  typedef struct packed {
    logic [QUO_W-1:0]      rad;
    logic [ROOT_REM_W-1:0] rem;
    logic [BYTE_W-1:0]     root;
  } sqrt_chan_t;

  typedef struct packed {
    sqrt_chan_t [CHANNELS-1:0] ch;
    logic [CHANNELS-1:0]       sat;
    logic                      frame_end;
  } sqrt_pipe_t;

endpackage

// File: rtl/core/prgq_ifs.sv
`timescale 1ns / 1ps

interface prgq_pix_in_if
  import prgq_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [SUM_WIDTH-1:0] red_sum;
  logic [SUM_WIDTH-1:0] green_sum;
  logic [SUM_WIDTH-1:0] blue_sum;
  logic                 frame_end;

  modport source (output valid, output red_sum, output green_sum, output blue_sum,
                  output frame_end, input ready);
  modport sink (input valid, input red_sum, input green_sum, input blue_sum,
                input frame_end, output ready);
endinterface

interface prgq_pix_out_if
  import prgq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_byte;
  logic [BYTE_W-1:0] green_byte;
  logic [BYTE_W-1:0] blue_byte;
  logic              frame_end_out;

  modport source (output valid, output red_byte, output green_byte, output blue_byte,
                  output frame_end_out, input ready);
  modport sink (input valid, input red_byte, input green_byte, input blue_byte,
                input frame_end_out, output ready);
endinterface

// File: rtl/core/prgq_div_stage.sv
`timescale 1ns / 1ps

module prgq_div_stage
  import prgq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  div_pipe_t        in_data,
  input  logic [QUO_W-1:0] divisor,
  output logic             out_valid,
  output div_pipe_t        out_data
);

  logic      valid_r;
  div_pipe_t data_r;
  div_pipe_t data_nxt;

  // One restoring division step: bring down the next dividend bit and
  // subtract the divisor where it fits.
  function automatic div_chan_t div_step(div_chan_t c, logic [QUO_W-1:0] d);
    logic [QUO_W:0] t;
    logic [QUO_W:0] diff;
    div_chan_t      r;
    t    = {c.rem, c.word[QUO_W-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r.rem  = diff[QUO_W-1:0];
      r.word = {c.word[QUO_W-2:0], 1'b1};
    end else begin
      r.rem  = t[QUO_W-1:0];
      r.word = {c.word[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    data_nxt = in_data;
    for (int s = 0; s < DIV_STEPS; s++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        data_nxt.ch[c] = div_step(data_nxt.ch[c], divisor);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: rtl/core/prgq_sqrt_stage.sv
`timescale 1ns / 1ps

module prgq_sqrt_stage
  import prgq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  sqrt_pipe_t in_data,
  output logic       out_valid,
  output sqrt_pipe_t out_data
);

  logic       valid_r;
  sqrt_pipe_t data_r;
  sqrt_pipe_t data_nxt;

  // Digit-by-digit square root: two radicand bits in, one root bit out.
  function automatic sqrt_chan_t sqrt_step(sqrt_chan_t c);
    logic [ROOT_REM_W+1:0] t;
    logic [ROOT_REM_W+1:0] trial;
    logic [ROOT_REM_W+1:0] diff;
    sqrt_chan_t            r;
    t     = {c.rem, c.rad[QUO_W-1 -: 2]};
    trial = (ROOT_REM_W + 2)'({c.root, 2'b01});
    diff  = t - trial;
    r.rad = {c.rad[QUO_W-3:0], 2'b00};
    if (t >= trial) begin
      r.rem  = diff[ROOT_REM_W-1:0];
      r.root = {c.root[BYTE_W-2:0], 1'b1};
    end else begin
      r.rem  = t[ROOT_REM_W-1:0];
      r.root = {c.root[BYTE_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    data_nxt = in_data;
    for (int s = 0; s < SQRT_STEPS; s++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        data_nxt.ch[c] = sqrt_step(data_nxt.ch[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: rtl/core/pixel_resolve_gamma_quantize_top.sv
`timescale 1ns / 1ps

// Pixel resolve: averages three accumulated Q16.16 radiance sums over the
// samples-per-pixel count, applies gamma 2 and quantizes each channel to a byte.
// The input channel in_pix carries one pixel's sums and an end-of-frame flag;
// the result channel out_pix carries the three bytes and the flag copy. Both
// use valid/ready, and an item moves on an edge where both are high.
// The user must write the divisor via cfg_we/cfg_wdata only while no item is in
// flight; the block does not enforce this. Zero acts as one and reset sets one.
// The pipeline has eight register stages: input capture, four stages of the
// divider (four quotient bits each), two square-root stages (four root bits
// each) and the output register. One item per cycle is taken in steady state while
// the receiver holds ready high. Reset empties every stage. When the receiver holds
// ready low the result stays on the port; upstream stages keep filling any empty
// slots and input ready falls only once all eight stages hold an item.
module pixel_resolve_gamma_quantize_top
  import prgq_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  prgq_pix_in_if.sink      in_pix,
  prgq_pix_out_if.source   out_pix,
  input  logic             cfg_we,
  input  logic [QUO_W-1:0] cfg_wdata
);

  localparam int HI_W   = SUM_WIDTH - FRAC_BITS;
  localparam int CMP_W  = (HI_W > QUO_W) ? HI_W : QUO_W;
  localparam int NST    = 1 + DIV_STAGES + SQRT_STAGES + 1;
  localparam int OUT_ST = NST - 1;

  logic [QUO_W-1:0]     div_r;
  logic [NST-1:0]       st_en;
  logic [NST-1:0]       st_v;

  logic [SUM_WIDTH-1:0] sums [CHANNELS];
  logic [CMP_W-1:0]     hi_ext [CHANNELS];
  div_pipe_t            in_nxt;
  div_pipe_t            in_r;
  logic                 in_v_r;

  div_pipe_t            div_q [DIV_STAGES+1];
  logic [DIV_STAGES:0]  div_v;
  sqrt_pipe_t           sqrt_q [SQRT_STAGES+1];
  logic [SQRT_STAGES:0] sqrt_v;

  logic                 out_v_r;
  logic [BYTE_W-1:0]    byte_r [CHANNELS];
  logic                 fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= QUO_W'(1);
    end else if (cfg_we) begin
      div_r <= (cfg_wdata == '0) ? QUO_W'(1) : cfg_wdata;
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    st_en[NST-1] = !st_v[NST-1] || out_pix.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      st_en[k] = !st_v[k] || st_en[k+1];
    end
  end

  assign st_v         = {out_v_r, sqrt_v[SQRT_STAGES:1], div_v[DIV_STAGES:1], in_v_r};
  assign in_pix.ready = st_en[0];

  assign sums[0] = in_pix.red_sum;
  assign sums[1] = in_pix.green_sum;
  assign sums[2] = in_pix.blue_sum;

  // The mean reaches 1.0 exactly when the integer part of the sum is at least
  // the divisor; otherwise the integer part is the first partial remainder.
  always_comb begin
    in_nxt.frame_end = in_pix.frame_end;
    for (int c = 0; c < CHANNELS; c++) begin
      hi_ext[c]         = CMP_W'(sums[c][SUM_WIDTH-1:FRAC_BITS]);
      in_nxt.sat[c]     = hi_ext[c] >= CMP_W'(div_r);
      in_nxt.ch[c].rem  = hi_ext[c][QUO_W-1:0];
      in_nxt.ch[c].word = sums[c][FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (st_en[0]) begin
      in_v_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_en[0]) begin
      in_r <= in_nxt;
    end
  end

  assign div_q[0] = in_r;
  assign div_v[0] = in_v_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    prgq_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (st_en[1+g]),
      .in_valid  (div_v[g]),
      .in_data   (div_q[g]),
      .divisor   (div_r),
      .out_valid (div_v[g+1]),
      .out_data  (div_q[g+1])
    );
  end

  always_comb begin
    sqrt_q[0].sat       = div_q[DIV_STAGES].sat;
    sqrt_q[0].frame_end = div_q[DIV_STAGES].frame_end;
    for (int c = 0; c < CHANNELS; c++) begin
      sqrt_q[0].ch[c].rad  = div_q[DIV_STAGES].ch[c].word;
      sqrt_q[0].ch[c].rem  = '0;
      sqrt_q[0].ch[c].root = '0;
    end
  end
  assign sqrt_v[0] = div_v[DIV_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    prgq_sqrt_stage u_sqrt (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (st_en[1+DIV_STAGES+g]),
      .in_valid  (sqrt_v[g]),
      .in_data   (sqrt_q[g]),
      .out_valid (sqrt_v[g+1]),
      .out_data  (sqrt_q[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (st_en[OUT_ST]) begin
      out_v_r <= sqrt_v[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (st_en[OUT_ST]) begin
      fe_r <= sqrt_q[SQRT_STAGES].frame_end;
      for (int c = 0; c < CHANNELS; c++) begin
        byte_r[c] <= sqrt_q[SQRT_STAGES].sat[c] ? BYTE_MAX : sqrt_q[SQRT_STAGES].ch[c].root;
      end
    end
  end

  assign out_pix.valid         = out_v_r;
  assign out_pix.red_byte      = byte_r[0];
  assign out_pix.green_byte    = byte_r[1];
  assign out_pix.blue_byte     = byte_r[2];
  assign out_pix.frame_end_out = fe_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_r != '0)
    else $error("divisor register holds zero");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> ((&st_v) && !out_pix.ready))
    else $error("input blocked while the pipeline has an empty stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> st_v[0])
    else $error("accepted item did not enter the first stage");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_v[SQRT_STAGES] |->
      (sqrt_q[SQRT_STAGES].ch[0].rem <= {1'b0, sqrt_q[SQRT_STAGES].ch[0].root, 1'b0}))
    else $error("square root remainder exceeds twice the root");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import prgq_pkg::*;

  localparam int SUM_WIDTH  = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int DIRECTED_COUNT = 12;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              frame_end;
  } pixel_bytes_t;

  typedef struct packed {
    logic [SUM_WIDTH-1:0] red_sum;
    logic [SUM_WIDTH-1:0] green_sum;
    logic [SUM_WIDTH-1:0] blue_sum;
    logic                 frame_end;
    logic                 typed;
    pixel_bytes_t         bytes;
  } pixel_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [QUO_W-1:0] cfg_wdata;

  prgq_pix_in_if #(.SUM_WIDTH(SUM_WIDTH)) pix_in ();
  prgq_pix_out_if pix_out ();

  pixel_resolve_gamma_quantize_top #(
    .SUM_WIDTH(SUM_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_in),
    .out_pix  (pix_out),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  pixel_bytes_t     expected_pixels[$];
  logic [QUO_W-1:0] spp_setting;
  int               mismatches;
  int               burst_left;
  pixel_row_t       directed_rows [0:DIRECTED_COUNT-1];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root of the averaged Q16.16 value, saturated to a byte.
  function automatic logic [BYTE_W-1:0] gamma_byte(logic [SUM_WIDTH-1:0] sum,
                                                   logic [QUO_W-1:0] divisor);
    logic [SUM_WIDTH-1:0] mean;
    logic [31:0]          trial;
    logic [BYTE_W-1:0]    root;
    mean = sum / ((divisor == '0) ? 1 : divisor);
    if (mean >= 32'h0001_0000) begin
      return BYTE_MAX;
    end
    root = '0;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      trial = 32'(root) | (32'd1 << b);
      if (trial * trial <= mean) begin
        root = trial[BYTE_W-1:0];
      end
    end
    return root;
  endfunction

  function automatic pixel_bytes_t resolve_pixel(pixel_row_t row, logic [QUO_W-1:0] divisor);
    pixel_bytes_t px;
    px.red       = gamma_byte(row.red_sum, divisor);
    px.green     = gamma_byte(row.green_sum, divisor);
    px.blue      = gamma_byte(row.blue_sum, divisor);
    px.frame_end = row.frame_end;
    return px;
  endfunction

  // Sums are biased toward means below 1.0, where the root is not saturated.
  function automatic logic [SUM_WIDTH-1:0] random_sum(logic [QUO_W-1:0] divisor);
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] wide;
    int          r;
    d = (divisor == '0) ? 64'd1 : 64'(divisor);
    wide = '0;
    case ($urandom_range(0, 9))
      0, 1, 2: wide = 64'($urandom());
      3, 4, 5, 6: begin
        q = 64'($urandom_range(0, 65535));
        wide = q * d + 64'($urandom_range(0, int'(d) - 1));
      end
      7: begin
        r = $urandom_range(0, 256);
        q = 64'(r * r);
        if (r != 0 && $urandom_range(0, 1) == 1) begin
          q = q - 1;
        end
        wide = q * d;
        if ($urandom_range(0, 1) == 1) begin
          wide = wide + d - 1;
        end
      end
      8: wide = ($urandom_range(0, 1) == 1) ? 64'hFFFF_FFFF : 64'd0;
      default: wide = 64'($urandom_range(0, 1023));
    endcase
    return wide[SUM_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string field, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
    end
  endtask

  // Presents one item from the falling edge and holds it until it is taken.
  task automatic offer_pixel(pixel_row_t row);
    pix_in.valid     <= 1'b1;
    pix_in.red_sum   <= row.red_sum;
    pix_in.green_sum <= row.green_sum;
    pix_in.blue_sum  <= row.blue_sum;
    pix_in.frame_end <= row.frame_end;
    do begin
      @(posedge clk);
    end while (!pix_in.ready);
    expected_pixels.push_back(row.typed ? row.bytes : resolve_pixel(row, spp_setting));
    @(negedge clk);
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // The divisor only changes once the pipeline has emptied.
  task automatic write_divisor(logic [QUO_W-1:0] value);
    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we      <= 1'b0;
    spp_setting = value;
  endtask

  task automatic run_random_phase(logic [QUO_W-1:0] divisor);
    pixel_row_t row;
    write_divisor(divisor);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      pace_sender();
      row.red_sum   = random_sum(divisor);
      row.green_sum = random_sum(divisor);
      row.blue_sum  = random_sum(divisor);
      row.frame_end = ($urandom_range(0, 15) == 0);
      row.typed     = 1'b0;
      row.bytes     = '0;
      offer_pixel(row);
    end
  endtask

  // Result checker.
  initial begin
    pixel_bytes_t want;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pix_out.valid && pix_out.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d/%0d with no item pending",
                                    pix_out.red_byte, pix_out.green_byte,
                                    pix_out.blue_byte, pix_out.frame_end_out));
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_byte", pix_out.red_byte, want.red);
          check_field("green_byte", pix_out.green_byte, want.green);
          check_field("blue_byte", pix_out.blue_byte, want.blue);
          check_field("frame_end_out", pix_out.frame_end_out, want.frame_end);
        end
      end
    end
  end

  // Receiver: segments of different stall patterns, with two long hold-offs
  // that let the pipeline fill and push back on the sender.
  initial begin
    int segment;
    int mode;
    int len;
    segment = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      len = $urandom_range(10, 150);
      mode = $urandom_range(0, 3);
      if (segment == 3 || segment == 15) begin
        pix_out.ready <= 1'b0;
        repeat (120) @(negedge clk);
      end else begin
        for (int c = 0; c < len; c++) begin
          case (mode)
            0: pix_out.ready <= 1'b1;
            1: pix_out.ready <= ($urandom_range(0, 3) != 0);
            2: pix_out.ready <= ($urandom_range(0, 9) < 3);
            default: pix_out.ready <= (c % 4 != 3);
          endcase
          @(negedge clk);
        end
      end
      segment++;
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    pix_in.valid     = 1'b0;
    pix_in.red_sum   = '0;
    pix_in.green_sum = '0;
    pix_in.blue_sum  = '0;
    pix_in.frame_end = 1'b0;
    pix_out.ready    = 1'b0;
    spp_setting      = 16'd1;
    mismatches       = 0;
    burst_left       = 0;

    // Directed rows run at the reset divisor of one. Rows with typed = 1
    // carry their bytes; the rest go through the predictor.
    directed_rows = '{
      '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{8'd255, 8'd255, 8'd255, 1'b1}},
      '{32'd65535, 32'd65536, 32'd65025, 1'b0, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
      '{32'd65024, 32'd1, 32'd0, 1'b1, 1'b1, '{8'd254, 8'd1, 8'd0, 1'b1}},
      '{32'd3, 32'd4, 32'd8, 1'b0, 1'b1, '{8'd1, 8'd2, 8'd2, 1'b0}},
      '{32'd16384, 32'd16383, 32'd32768, 1'b0, 1'b0, '0},
      '{32'h8000_0000, 32'h0000_FFFF, 32'h0001_0000, 1'b1, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_AAAA, 1'b1, 1'b0, '0},
      '{32'h0000_5555, 32'h0000_A5A5, 32'h0000_0100, 1'b0, 1'b0, '0},
      '{32'd100, 32'd99, 32'd121, 1'b0, 1'b0, '0},
      '{32'h0000_FF00, 32'h0000_7FFF, 32'h0001_FFFF, 1'b1, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h0000_0002, 32'h0000_3FFF, 1'b0, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      pace_sender();
      offer_pixel(directed_rows[i]);
    end

    // A divisor of zero acts as one; the full-scale divisor comes next.
    run_random_phase(16'd0);
    run_random_phase(16'hFFFF);
    run_random_phase(16'd1);
    run_random_phase(16'd2);
    run_random_phase(16'($urandom_range(3, 64)));
    run_random_phase(16'($urandom_range(65, 4095)));
    run_random_phase(16'($urandom_range(4096, 65534)));
    run_random_phase(16'd1);

    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
